// File: src/u8sv_pkg.sv
// Shared constants for the UTF-8 stream validator.
// Byte masks, lead patterns and code point limits; no dependencies.
`timescale 1ns / 1ps

package u8sv_pkg;

    // Byte classification masks and patterns
    localparam logic [7:0] ASCII_MAX   = 8'h7F;
    localparam logic [7:0] LEAD2_MASK  = 8'hE0;
    localparam logic [7:0] LEAD2_PAT   = 8'hC0;
    localparam logic [7:0] LEAD3_MASK  = 8'hF0;
    localparam logic [7:0] LEAD3_PAT   = 8'hE0;
    localparam logic [7:0] LEAD4_MASK  = 8'hF8;
    localparam logic [7:0] LEAD4_PAT   = 8'hF0;
    localparam logic [7:0] CONT_MASK   = 8'hC0;
    localparam logic [7:0] CONT_PAT    = 8'h80;
    localparam logic [7:0] NUL_BYTE    = 8'h00;

    // Minimum two-byte lead payload (0xC0/0xC1 are overlong)
    localparam logic [4:0] LEAD2_MIN   = 5'd2;

    // Code point limits
    localparam int unsigned CP_W       = 21;
    localparam logic [CP_W-1:0] CP_MIN3   = 21'h000800;
    localparam logic [CP_W-1:0] CP_MIN4   = 21'h010000;
    localparam logic [CP_W-1:0] SURR_LO   = 21'h00D800;
    localparam logic [CP_W-1:0] SURR_HI   = 21'h00DFFF;
    localparam logic [CP_W-1:0] CP_MAX    = 21'h10FFFF;

    // Continuation counts
    localparam logic [1:0] OWE_NONE  = 2'd0;
    localparam logic [1:0] OWE_ONE   = 2'd1;
    localparam logic [1:0] OWE_TWO   = 2'd2;
    localparam logic [1:0] OWE_THREE = 2'd3;

endpackage

// File: src/utf8_stream_validator_core.sv
// UTF-8 stream validator top level: input register, decode/update logic,
// result register. Uses u8sv_pkg for byte patterns and code point limits.
// A last byte is held in the input register; its verdict is then registered.
// Throughput: one byte per cycle unless a waiting verdict stalls input; the
// per-byte state update is the loop that sets this rate. A verdict waiting at
// the output stalls input only when the byte held in the input register is a last byte.
// Reset (rst_n, async, active low) clears all pipeline valids and text state.
`timescale 1ns / 1ps

module utf8_stream_validator_core
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] data_byte,
    input  logic       is_last,
    output logic       out_valid,
    input  logic       out_ready,
    output logic       text_valid
);
    import u8sv_pkg::*;

    // Input stage
    logic            s1_valid_reg;
    logic            s1_valid_next;
    logic [7:0]      s1_byte_reg;
    logic            s1_last_reg;

    // Text state
    logic [1:0]      owed_reg;
    logic [1:0]      owed_next;
    logic [1:0]      seq_len_reg;
    logic [1:0]      seq_len_next;
    logic [CP_W-1:0] cp_reg;
    logic [CP_W-1:0] cp_next;
    logic            err_reg;
    logic            err_next;

    // Result stage
    logic            out_valid_reg;
    logic            out_valid_next;
    logic            text_valid_reg;
    logic            text_valid_next;

    // Decode scratch
    logic            advance;
    logic            accept;
    logic [1:0]      upd_owed;
    logic [1:0]      upd_seq;
    logic [CP_W-1:0] upd_cp;
    logic            upd_err;
    logic [CP_W-1:0] shifted_cp;
    logic [1:0]      dec_owed;

    // Handshake: a last beat moves on only when the result slot frees up
    assign advance  = s1_valid_reg && (!s1_last_reg || !out_valid_reg || out_ready);
    assign in_ready = !s1_valid_reg || advance;
    assign accept   = in_valid && in_ready;

    assign out_valid  = out_valid_reg;
    assign text_valid = text_valid_reg;

    // Fold the registered byte into the text state
    assign shifted_cp = {cp_reg[CP_W-7:0], s1_byte_reg[5:0]};
    assign dec_owed   = owed_reg - 2'd1;

    always_comb
    begin
        upd_owed = owed_reg;
        upd_seq  = seq_len_reg;
        upd_cp   = cp_reg;
        upd_err  = err_reg;
        if (!err_reg)
        begin
            if (owed_reg == OWE_NONE)
            begin
                if (s1_byte_reg <= ASCII_MAX)
                begin
                    if (s1_byte_reg == NUL_BYTE)
                        upd_err = 1'b1;
                end
                else if ((s1_byte_reg & LEAD2_MASK) == LEAD2_PAT)
                begin
                    upd_cp   = {{(CP_W-5){1'b0}}, s1_byte_reg[4:0]};
                    upd_owed = OWE_ONE;
                    upd_seq  = OWE_ONE;
                    if (s1_byte_reg[4:0] < LEAD2_MIN)
                        upd_err = 1'b1;
                end
                else if ((s1_byte_reg & LEAD3_MASK) == LEAD3_PAT)
                begin
                    upd_cp   = {{(CP_W-4){1'b0}}, s1_byte_reg[3:0]};
                    upd_owed = OWE_TWO;
                    upd_seq  = OWE_TWO;
                end
                else if ((s1_byte_reg & LEAD4_MASK) == LEAD4_PAT)
                begin
                    upd_cp   = {{(CP_W-3){1'b0}}, s1_byte_reg[2:0]};
                    upd_owed = OWE_THREE;
                    upd_seq  = OWE_THREE;
                end
                else
                begin
                    upd_err = 1'b1;
                end
            end
            else if ((s1_byte_reg & CONT_MASK) != CONT_PAT)
            begin
                upd_err = 1'b1;
            end
            else
            begin
                upd_cp   = shifted_cp;
                upd_owed = dec_owed;
                if (dec_owed == OWE_NONE)
                begin
                    if ((seq_len_reg == OWE_TWO && shifted_cp < CP_MIN3) ||
                        (seq_len_reg == OWE_THREE && shifted_cp < CP_MIN4) ||
                        (shifted_cp >= SURR_LO && shifted_cp <= SURR_HI) ||
                        (shifted_cp > CP_MAX))
                        upd_err = 1'b1;
                end
            end
        end
    end

    // Next state: clear after a last beat, hold when idle
    always_comb
    begin
        owed_next       = owed_reg;
        seq_len_next    = seq_len_reg;
        cp_next         = cp_reg;
        err_next        = err_reg;
        out_valid_next  = out_valid_reg && !out_ready;
        text_valid_next = text_valid_reg;
        s1_valid_next   = accept ? 1'b1 : (s1_valid_reg && !advance);
        if (advance)
        begin
            if (s1_last_reg)
            begin
                owed_next       = OWE_NONE;
                seq_len_next    = OWE_NONE;
                cp_next         = '0;
                err_next        = 1'b0;
                out_valid_next  = 1'b1;
                text_valid_next = !upd_err && (upd_owed == OWE_NONE);
            end
            else
            begin
                owed_next    = upd_owed;
                seq_len_next = upd_seq;
                cp_next      = upd_cp;
                err_next     = upd_err;
            end
        end
    end

    // Control and state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            owed_reg      <= OWE_NONE;
            seq_len_reg   <= OWE_NONE;
            cp_reg        <= '0;
            err_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            owed_reg      <= owed_next;
            seq_len_reg   <= seq_len_next;
            cp_reg        <= cp_next;
            err_reg       <= err_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers: capture the beat, hold the verdict
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_byte_reg <= data_byte;
            s1_last_reg <= is_last;
        end
        text_valid_reg <= text_valid_next;
    end

    // Text state is clear after a last byte is folded in
    a_clear_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        advance && s1_last_reg |=> owed_reg == OWE_NONE && !err_reg && cp_reg == '0)
        else $error("text state not cleared after last byte");

    // Owed count never exceeds the sequence length
    a_owed_le_seq: assert property (@(posedge clk) disable iff (!rst_n)
        owed_reg <= seq_len_reg)
        else $error("owed continuation count exceeds sequence length");

    // A verdict appears only after a last byte advanced
    a_verdict_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(advance && s1_last_reg))
        else $error("verdict without a last byte");

    // An empty input stage always takes a beat
    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !s1_valid_reg |-> in_ready)
        else $error("input stalled with empty stage");

endmodule

// File: verif/utf8_stream_validator_core_tb.sv
// Self-checking testbench for utf8_stream_validator_core: streams texts byte by byte and
// checks each end-of-text verdict against a cycle-free predictor of the UTF-8 rules.
// Depends on u8sv_pkg (byte patterns, code point limits) and the core RTL.
`timescale 1ns / 1ps

module utf8_stream_validator_core_tb;

    import u8sv_pkg::*;

    localparam int unsigned CYCLE_LIMIT = 200000;

    // Kinds of malformed material mixed into random texts
    typedef enum int
    {
        JUNK_RAW_BYTE,
        JUNK_OVERLONG,
        JUNK_SURROGATE,
        JUNK_TOO_BIG,
        JUNK_TRUNCATED,
        JUNK_NUL,
        JUNK_BAD_CONT
    } junk_kind_t;

    // One input beat as queued for the driver
    typedef struct
    {
        logic [7:0] data;
        logic       last;
        logic       wait_idle;
    } text_beat_t;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       in_valid = 1'b0;
    logic       in_ready;
    logic [7:0] data_byte = 8'h00;
    logic       is_last = 1'b0;
    logic       out_valid;
    logic       out_ready = 1'b0;
    logic       text_valid;

    text_beat_t  beat_q[$];
    logic [7:0]  text_bytes[$];
    logic        verdict_q[$];

    // Predictor state for the text in progress
    logic [1:0]  owed;
    logic [1:0]  seq_len;
    logic [20:0] cp_acc;
    logic        bad_text;

    int unsigned mismatches = 0;
    int unsigned verdicts_seen = 0;
    int unsigned verdicts_good = 0;
    int unsigned texts_sent = 0;
    int unsigned cycle_count = 0;
    int unsigned rx_cycle = 0;
    int unsigned rx_hold_left = 0;
    int unsigned burst_left = 0;
    int unsigned gap_left = 0;
    logic        beat_took = 1'b0;
    text_beat_t  next_beat;

    utf8_stream_validator_core u_dut
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .data_byte  (data_byte),
        .is_last    (is_last),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .text_valid (text_valid)
    );

    always #1 clk = ~clk;

    task automatic report_mismatch(input string what, input logic expd, input logic got);
        $display("MISMATCH @%0t: %s (expected %0b, got %0b)", $realtime, what, expd, got);
        mismatches++;
    endtask

    // Advance the predictor by one byte; queue a verdict on the last byte
    task automatic absorb_byte(input logic [7:0] b, input logic last);
        if (!bad_text)
        begin
            if (owed == OWE_NONE)
            begin
                if (b <= ASCII_MAX)
                begin
                    if (b == NUL_BYTE)
                        bad_text = 1'b1;
                end
                else if ((b & LEAD2_MASK) == LEAD2_PAT)
                begin
                    cp_acc = {16'd0, b[4:0]};
                    if (b[4:0] < LEAD2_MIN)
                        bad_text = 1'b1;
                    owed = OWE_ONE;
                    seq_len = OWE_ONE;
                end
                else if ((b & LEAD3_MASK) == LEAD3_PAT)
                begin
                    cp_acc = {17'd0, b[3:0]};
                    owed = OWE_TWO;
                    seq_len = OWE_TWO;
                end
                else if ((b & LEAD4_MASK) == LEAD4_PAT)
                begin
                    cp_acc = {18'd0, b[2:0]};
                    owed = OWE_THREE;
                    seq_len = OWE_THREE;
                end
                else
                    bad_text = 1'b1;
            end
            else if ((b & CONT_MASK) != CONT_PAT)
                bad_text = 1'b1;
            else
            begin
                cp_acc = {cp_acc[14:0], b[5:0]};
                owed = owed - 2'd1;
                if (owed == OWE_NONE)
                begin
                    if ((seq_len == OWE_TWO && cp_acc < CP_MIN3) ||
                        (seq_len == OWE_THREE && cp_acc < CP_MIN4) ||
                        (cp_acc >= SURR_LO && cp_acc <= SURR_HI) ||
                        cp_acc > CP_MAX)
                        bad_text = 1'b1;
                end
            end
        end
        if (last)
        begin
            verdict_q.push_back(!(bad_text || owed != OWE_NONE));
            owed = OWE_NONE;
            seq_len = OWE_NONE;
            cp_acc = '0;
            bad_text = 1'b0;
        end
    endtask

    // Encode raw bits in an n-byte form, overlong and out-of-range forms included
    task automatic add_seq(input logic [20:0] cp, input int n);
        case (n)
            1: text_bytes.push_back(cp[7:0]);
            2:
            begin
                text_bytes.push_back({3'b110, cp[10:6]});
                text_bytes.push_back({2'b10, cp[5:0]});
            end
            3:
            begin
                text_bytes.push_back({4'b1110, cp[15:12]});
                text_bytes.push_back({2'b10, cp[11:6]});
                text_bytes.push_back({2'b10, cp[5:0]});
            end
            default:
            begin
                text_bytes.push_back({5'b11110, cp[20:18]});
                text_bytes.push_back({2'b10, cp[17:12]});
                text_bytes.push_back({2'b10, cp[11:6]});
                text_bytes.push_back({2'b10, cp[5:0]});
            end
        endcase
    endtask

    // Append one well-formed character of random length
    task automatic add_good_char();
        logic [20:0] cp;
        int          n;
        n = $urandom_range(1, 4);
        case (n)
            1: cp = 21'($urandom_range(1, 21'h7F));
            2: cp = 21'($urandom_range(21'h80, 21'h7FF));
            3:
            begin
                cp = 21'($urandom_range(21'h800, 21'hFFFF));
                if (cp >= SURR_LO && cp <= SURR_HI)
                    cp = cp ^ 21'h2000;
            end
            default: cp = 21'($urandom_range(21'h10000, 21'h10FFFF));
        endcase
        add_seq(cp, n);
    endtask

    // Append one piece of malformed material
    task automatic add_junk();
        junk_kind_t  kind;
        int          n;
        kind = junk_kind_t'($urandom_range(0, 6));
        case (kind)
            JUNK_RAW_BYTE: text_bytes.push_back(8'($urandom_range(0, 255)));
            JUNK_OVERLONG:
            begin
                n = $urandom_range(2, 4);
                if (n == 2)
                    add_seq(21'($urandom_range(0, 21'h7F)), 2);
                else if (n == 3)
                    add_seq(21'($urandom_range(0, 21'h7FF)), 3);
                else
                    add_seq(21'($urandom_range(0, 21'hFFFF)), 4);
            end
            JUNK_SURROGATE: add_seq(21'($urandom_range(SURR_LO, SURR_HI)), 3);
            JUNK_TOO_BIG: add_seq(21'($urandom_range(21'h110000, 21'h1FFFFF)), 4);
            JUNK_TRUNCATED:
            begin
                n = $urandom_range(2, 4);
                add_seq(21'($urandom_range(21'h10000, 21'h10FFFF) >> (6 * (4 - n))), n);
                repeat ($urandom_range(1, n - 1))
                    void'(text_bytes.pop_back());
            end
            JUNK_NUL: text_bytes.push_back(NUL_BYTE);
            default:
            begin
                text_bytes.push_back(8'($urandom_range(8'hC2, 8'hF4)));
                if ($urandom_range(0, 1))
                    text_bytes.push_back(8'($urandom_range(8'h00, 8'h7F)));
                else
                    text_bytes.push_back(8'($urandom_range(8'hC0, 8'hFF)));
            end
        endcase
    endtask

    // Move the staged text into the driver queue, marking its last byte
    task automatic end_text(input logic wait_idle);
        text_beat_t b;
        for (int i = 0; i < text_bytes.size(); i++)
        begin
            b.data = text_bytes[i];
            b.last = (i == text_bytes.size() - 1);
            b.wait_idle = wait_idle && (i == 0);
            beat_q.push_back(b);
        end
        text_bytes.delete();
        texts_sent++;
    endtask

    // Fill the stimulus queue, then wait for the run to drain
    initial
    begin
        int n_chars;
        int junk_rate;

        owed = OWE_NONE;
        seq_len = OWE_NONE;
        cp_acc = '0;
        bad_text = 1'b0;

        // Directed texts: NUL, stray continuation, overlong leads and forms,
        // surrogate, beyond the top, top code point, sticky error, cut-off end
        add_seq(21'h00, 1);
        end_text(1'b0);
        add_seq(21'h80, 1);
        end_text(1'b0);
        add_seq(21'h7F, 2);
        end_text(1'b0);
        add_seq(21'h7FF, 3);
        end_text(1'b0);
        add_seq(SURR_LO, 3);
        end_text(1'b0);
        add_seq(21'hFFFF, 4);
        end_text(1'b1);
        add_seq(21'h110000, 4);
        end_text(1'b0);
        add_seq(CP_MAX, 4);
        end_text(1'b0);
        add_seq(21'h80, 2);
        void'(text_bytes.pop_back());
        add_seq(21'h41, 1);
        add_seq(21'h42, 1);
        end_text(1'b0);
        add_seq(21'h20AC, 3);
        void'(text_bytes.pop_back());
        end_text(1'b0);

        // Random texts: mostly well formed, some with junk mixed in
        while (beat_q.size() < 1030)
        begin
            n_chars = ($urandom_range(0, 3) == 0) ? 1 : $urandom_range(1, 10);
            junk_rate = ($urandom_range(0, 9) < 7) ? 0 : $urandom_range(1, 4);
            for (int c = 0; c < n_chars; c++)
            begin
                if (junk_rate != 0 && $urandom_range(1, 4) <= junk_rate)
                    add_junk();
                else
                    add_good_char();
            end
            end_text($urandom_range(0, 39) == 0);
        end

        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        while (beat_q.size() != 0 || in_valid)
            @(posedge clk);
        while (verdict_q.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);

        $display("Streamed %0d texts in %0d cycles; %0d verdicts checked (%0d valid, %0d invalid).",
                 texts_sent, cycle_count, verdicts_seen, verdicts_good,
                 verdicts_seen - verdicts_good);
        if (mismatches == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

    // Drive beats in random bursts; hold a beat until it is taken
    always @(negedge clk)
    begin
        if (rst_n && (!in_valid || beat_took))
        begin
            if (gap_left > 0 && rx_hold_left == 0)
            begin
                gap_left--;
                in_valid <= 1'b0;
            end
            else if (beat_q.size() == 0 || (beat_q[0].wait_idle && verdict_q.size() != 0))
                in_valid <= 1'b0;
            else
            begin
                next_beat = beat_q.pop_front();
                data_byte <= next_beat.data;
                is_last <= next_beat.last;
                in_valid <= 1'b1;
                if (burst_left > 0)
                    burst_left--;
                else
                begin
                    burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(60, 150)
                                                             : $urandom_range(1, 20);
                    gap_left = $urandom_range(1, 6);
                end
            end
        end
    end

    // Stall the result side; the mode rotates through four patterns, with two long holds
    always @(negedge clk)
    begin
        rx_cycle++;
        if (rx_cycle == 300 || rx_cycle == 1500)
            rx_hold_left = 120;
        if (rx_hold_left > 0)
        begin
            rx_hold_left--;
            out_ready <= 1'b0;
        end
        else
        begin
            case ((rx_cycle >> 9) % 4)
                0: out_ready <= 1'b1;
                1: out_ready <= 1'($urandom_range(0, 1));
                2: out_ready <= ($urandom_range(0, 7) == 0);
                default: out_ready <= ($urandom_range(0, 3) != 0);
            endcase
        end
    end

    // Check verdicts against the oldest expectation, then predict accepted beats
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                verdicts_seen++;
                if (verdict_q.size() == 0)
                    report_mismatch("verdict with no text pending", 1'bx, text_valid);
                else
                begin
                    if (text_valid !== verdict_q[0])
                        report_mismatch("text_valid", verdict_q[0], text_valid);
                    if (verdict_q[0])
                        verdicts_good++;
                    void'(verdict_q.pop_front());
                end
            end
            if (in_valid && in_ready)
                absorb_byte(data_byte, is_last);
            beat_took <= in_valid && in_ready;
        end
    end

    // Bound the run
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles, %0d verdicts outstanding.",
                     cycle_count, verdict_q.size());
            $display("simulation failed");
            $finish;
        end
    end

endmodule

// File: utf8_stream_validator_core.f
src/u8sv_pkg.sv
src/utf8_stream_validator_core.sv
verif/utf8_stream_validator_core_tb.sv
